[hdl/sha1_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 hasher package
// Shared types and constants for the byte stream hasher.
// ---------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = 1;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // Classified command from front to back.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       finish;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/sha1_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 front end
// Accepts input transactions, drops empty ones, and queues commands.
// ---------------------------------------------------------------------------
module sha1_front import sha1_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_present_i,
  input  wire logic       msg_end_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  cmd_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueueAw:0]   cnt_q, cnt_d;
  logic               push, pop, useful;

  assign ready_o     = (cnt_q != (QueueAw+1)'(QueueDepth));
  assign useful      = byte_present_i | msg_end_i;
  assign push        = valid_i & ready_o & useful;
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];

  // pointer update
  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: data_byte_i, has_byte: byte_present_i, finish: msg_end_i};
    end
  end

endmodule
`default_nettype wire

[hdl/sha1_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 back end
// Collects bytes into a block, runs 80 rounds one per cycle, pads and
// streams the digest.
// ---------------------------------------------------------------------------
module sha1_back import sha1_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_ready_o,
  input  wire cmd_t       cmd_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      digest_byte_o,
  output logic            digest_last_o
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPad   = 6'b000010,
    StRound = 6'b000100,
    StAdd   = 6'b001000,
    StOut   = 6'b010000,
    StFill  = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  w_q [16];
  logic [31:0]  h_q [5];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  logic [6:0]   rnd_q;
  logic [4:0]   oidx_q;
  logic         fin_q;   // message finish pending
  logic         pad_q;   // padding byte already placed
  logic         extra_q; // current block is the overflow block before length
  logic [5:0]   pos_q;   // padding write position

  logic [31:0] f, k, t, wnew;
  logic        accept;

  assign cmd_ready_o = (state_q == StIdle);
  assign accept      = cmd_valid_i & cmd_ready_o;

  // round function
  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t    = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + k;
    wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  assign out_valid_o   = (state_q == StOut);
  assign digest_last_o = (oidx_q == 5'd19);
  always_comb begin
    logic [31:0] hw;
    hw = h_q[oidx_q[4:2]];
    case (oidx_q[1:0])
      2'd0:    digest_byte_o = hw[31:24];
      2'd1:    digest_byte_o = hw[23:16];
      2'd2:    digest_byte_o = hw[15:8];
      default: digest_byte_o = hw[7:0];
    endcase
  end

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) begin
        if (cmd_i.has_byte && fill_q == 6'd63) state_d = StRound;
        else if (cmd_i.finish) state_d = StPad;
      end
      StPad:   state_d = (fill_q == 6'd63) ? StRound : StFill;
      StFill:  if (extra_q ? (pos_q == 6'd63) : (pos_q >= 6'd55)) state_d = StRound;
      StRound: if (rnd_q == 7'd79) state_d = StAdd;
      StAdd:   state_d = extra_q ? StFill : (fin_q ? (pad_q ? StOut : StPad) : StIdle);
      StOut:   if (out_ready_i && oidx_q == 5'd19) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      h_q     <= '{H0, H1, H2, H3, H4};
      fill_q  <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      pad_q   <= 1'b0;
      extra_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (cmd_i.has_byte) begin
              fill_q <= fill_q + 6'd1;
              bits_q <= bits_q + 64'd8;
            end
            fin_q <= cmd_i.finish;
            rnd_q <= '0;
          end
        end
        StPad: begin
          // 0x80 byte placed; zero/length fill starts after it
          pos_q   <= fill_q + 6'd1;
          extra_q <= (fill_q > 6'd55);
          pad_q   <= 1'b1;
          rnd_q   <= '0;
        end
        StFill: begin
          pos_q <= pos_q + 6'd1;
          rnd_q <= '0;
        end
        StRound: begin
          rnd_q <= rnd_q + 7'd1;
        end
        StAdd: begin
          h_q[0]  <= h_q[0] + a_q;
          h_q[1]  <= h_q[1] + b_q;
          h_q[2]  <= h_q[2] + c_q;
          h_q[3]  <= h_q[3] + d_q;
          h_q[4]  <= h_q[4] + e_q;
          fill_q  <= '0;
          pos_q   <= '0;
          oidx_q  <= '0;
          rnd_q   <= '0;
          extra_q <= 1'b0;
        end
        StOut: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 5'd1;
            if (oidx_q == 5'd19) begin
              h_q    <= '{H0, H1, H2, H3, H4};
              bits_q <= '0;
              fin_q  <= 1'b0;
              pad_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // message schedule window and working variables
  always_ff @(posedge clk_i) begin
    logic [7:0] by;
    logic [5:0] p;
    logic       wr;
    wr = 1'b0;
    by = '0;
    p  = '0;
    if (state_q == StIdle && accept && cmd_i.has_byte) begin
      wr = 1'b1; by = cmd_i.data; p = fill_q;
    end else if (state_q == StPad) begin
      wr = 1'b1; by = PadByte; p = fill_q;
    end else if (state_q == StFill && (extra_q || pos_q < 6'd56)) begin
      wr = 1'b1; by = 8'h00; p = pos_q;
    end
    if (wr) begin
      case (p[1:0])
        2'd0:    w_q[p[5:2]][31:24] <= by;
        2'd1:    w_q[p[5:2]][23:16] <= by;
        2'd2:    w_q[p[5:2]][15:8]  <= by;
        default: w_q[p[5:2]][7:0]   <= by;
      endcase
    end
    // last fill of the final block writes the bit length
    if (state_q == StFill && !extra_q && pos_q >= 6'd55) begin
      w_q[14] <= bits_q[63:32];
      w_q[15] <= bits_q[31:0];
    end
    // load working vars when a compression begins
    if (state_d == StRound && state_q != StRound) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end
    if (state_q == StRound) begin
      a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
  end

endmodule
`default_nettype wire

[hdl/sha1_byte_stream_hasher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Each byte is taken into the block buffer; a full block then runs the
// rounds and the add. Finish: pad fill, one or two compressions, then 20
// digest bytes, one per cycle while ready_i is high. The back end takes
// no bytes while its single-round compression loop runs. Reset is async,
// active low, and loads the initial hash values with an empty block.
// ---------------------------------------------------------------------------
module sha1_byte_stream_hasher import sha1_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       byte_present_i,
  input  wire logic       msg_end_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output logic [7:0]      digest_byte_o,
  output logic            digest_last_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  sha1_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_byte_i, .byte_present_i, .msg_end_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sha1_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o(valid_o), .out_ready_i(ready_i), .digest_byte_o, .digest_last_o
  );

endmodule
`default_nettype wire

[hdl/sha1_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-1 port checker
// Checks output handshake and digest framing at the top level ports.
// ---------------------------------------------------------------------------
module sha1_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_o,
  input wire logic       ready_i,
  input wire logic [7:0] digest_byte_o,
  input wire logic       digest_last_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(digest_byte_o))
    else $error("output transaction dropped");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && digest_last_o |=> !valid_o)
    else $error("output after last digest byte");

  a_no_double_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && ready_i && digest_last_o |=> !digest_last_o)
    else $error("repeated last flag");

endmodule

bind sha1_byte_stream_hasher sha1_checker u_checker (.*);
`default_nettype wire
